// ===== rtl/core/xs64s_pkg.sv =====
// Shared types, constants and helpers for the xorshift64* generator.
// No dependencies; every module of the block imports this package.
package xs64s_pkg;

  // Generator constants.
  localparam logic [63:0] GOLDEN_SEED = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] STAR_MULT   = 64'h2545f4914f6cdd1d;
  localparam int unsigned SHIFT_A     = 12;
  localparam int unsigned SHIFT_B     = 25;
  localparam int unsigned SHIFT_C     = 27;
  localparam int unsigned FRAC_SHIFT  = 11;

  // Register map: one 64-bit register at byte address 0.
  localparam int unsigned ADDR_W    = 3;
  localparam logic [ADDR_W-1:0] SEED_ADDR = '0;

  // Request kinds.
  typedef enum logic [1:0] {
    ACT_RAW  = 2'd0,
    ACT_MOD  = 2'd1,
    ACT_FRAC = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Which 32x32 partial product the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_req;
    logic     do_shift;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip_draw;
    logic is_mod;
    logic div_done;
    logic out_free;
  } sts_t;

  // Three shift-xor steps of one state advance.
  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] x;
    x = s;
    x = x ^ (x >> SHIFT_A);
    x = x ^ (x << SHIFT_B);
    x = x ^ (x >> SHIFT_C);
    return x;
  endfunction

endpackage

// ===== rtl/core/xs64s_ctrl.sv =====
// Sequencing state machine for the xorshift64* generator.
// Depends on xs64s_pkg; drives the datapath through cmd_t and reads sts_t.
module xs64s_ctrl
  import xs64s_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = sts.skip_draw ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: state_next = ST_MUL0;
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_ACC;
      ST_ACC:   state_next = sts.is_mod ? ST_DINIT : ST_DONE;
      ST_DINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall    = 1'b0;
        cmd.load_req = req_valid;
      end
      ST_SHIFT: cmd.do_shift = 1'b1;
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LL;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LH;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HL;
        cmd.acc_op  = ACC_ADD_HI;
      end
      ST_ACC:   cmd.acc_op   = ACC_ADD_HI;
      ST_DINIT: cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_DONE:  cmd.out_load = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  // The result register is only loaded when it can take the item.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is busy");

  // Divider steps only follow its initialization or another step.
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> ($past(cmd.div_init) || $past(cmd.div_step)))
    else $error("divider stepped without initialization");

  // A new item is taken only when the block is idle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |=> (req_stall || $past(sts.skip_draw)))
    else $error("block did not start work after taking an item");

endmodule

// ===== rtl/core/xs64s_dpath.sv =====
// Datapath of the xorshift64* generator: state word, shared 32x32 multiplier,
// bit-serial remainder unit and the output register. Depends on xs64s_pkg.
module xs64s_dpath
  import xs64s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_seed,
  input  logic [1:0]  action,
  input  logic [63:0] bound,
  input  logic        rsp_stall,
  output logic        rsp_valid,
  output logic [63:0] value,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [63:0] gen_state;
  action_t     act;
  logic [63:0] bnd;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] dvd;
  logic [63:0] rem;
  logic [5:0]  cnt;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] rem_sh;
  logic [64:0] rem_diff;
  logic [63:0] result;

  // Generator state: reseed on a register write, advance on command.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= GOLDEN_SEED;
    end else if (cfg_we) begin
      gen_state <= (cfg_seed != '0) ? cfg_seed : GOLDEN_SEED;
    end else if (cmd.do_shift) begin
      gen_state <= xorshift_step(gen_state);
    end
  end

  // Capture the request fields when an item is taken.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act <= action_t'(action);
      bnd <= bound;
    end
  end

  // Shared multiplier operands: one 32x32 partial product per cycle.
  always_comb begin
    case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = gen_state[31:0];
        mul_b = STAR_MULT[31:0];
      end
      MUL_LH: begin
        mul_a = gen_state[31:0];
        mul_b = STAR_MULT[63:32];
      end
      MUL_HL: begin
        mul_a = gen_state[63:32];
        mul_b = STAR_MULT[31:0];
      end
      default: begin
        mul_a = gen_state[31:0];
        mul_b = STAR_MULT[31:0];
      end
    endcase
  end

  // Product register, then accumulation of the low 64 bits.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {32'b0, mul_a} * {32'b0, mul_b};
    end
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod;
      ACC_ADD_HI: acc <= acc + {prod[31:0], 32'b0};
      default:    acc <= acc;
    endcase
  end

  // Restoring remainder unit, one dividend bit per cycle.
  assign rem_sh   = {rem, dvd[63]};
  assign rem_diff = rem_sh - {1'b0, bnd};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd <= acc;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[62:0], 1'b0};
      rem <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
      cnt <= cnt + 6'd1;
    end
  end

  // Result selection by request kind; skipped draws give zero.
  always_comb begin
    case (act)
      ACT_RAW:  result = acc;
      ACT_MOD:  result = (bnd != '0) ? rem : '0;
      ACT_FRAC: result = acc >> FRAC_SHIFT;
      default:  result = '0;
    endcase
  end

  // Output register decouples the result from the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value <= result;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.skip_draw = (action_t'(action) == ACT_NONE) ||
                    ((action_t'(action) == ACT_MOD) && (bound == '0));
    sts.is_mod    = (act == ACT_MOD);
    sts.div_done  = cmd.div_step && (cnt == 6'd63);
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  // An xorshift state that starts nonzero never reaches zero.
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    gen_state != '0)
    else $error("generator state became zero");

  // A fraction result leaves the integer bits clear.
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && (act == ACT_FRAC)) |=> (value[63:53] == '0))
    else $error("fraction result has bits above bit 52");

  // A reduced result always lies below its bound.
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && (act == ACT_MOD)) |-> ((bnd == '0) || (result < bnd)))
    else $error("reduced result not below bound");

endmodule

// ===== rtl/core/xorshift64_star_generator.sv =====
// Top level of the xorshift64* generator: register port, controller, datapath.
// Depends on xs64s_pkg, xs64s_ctrl and xs64s_dpath.
//
// One item is handled at a time. A raw or fraction draw runs one shift-xor
// step, three passes of a shared 32x32 multiplier plus one add for the low
// 64 bits of the product, and a load of the output register. A bounded draw
// adds the initialization and steps of the bit-serial remainder unit. A zero
// bound or the unused request code gives 0 without advancing the state. The
// result sits in an output register, so a new item is taken while it waits;
// the block only stalls at the end of an item if the previous result is
// still held. Writing the seed register (byte address 0) reloads the state
// immediately.
module xorshift64_star_generator
  import xs64s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [1:0]        action,
  input  logic [63:0]       bound,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [63:0]       value
);

  logic [63:0] seed_value;
  logic        cfg_we;
  cmd_t        cmd;
  sts_t        sts;

  // Register port: always ready, one seed register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == SEED_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= '0;
    end else if (cfg_we) begin
      seed_value <= pwdata;
    end
  end

  assign prdata = (paddr == SEED_ADDR) ? seed_value : '0;

  xs64s_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  xs64s_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_seed  (pwdata),
    .action    (action),
    .bound     (bound),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== verif/xs64s_checker.sv =====
// Checker for the xorshift64* generator: tracks the generator state from seed
// writes and accepted requests, and compares every returned value in order.
// Depends on xs64s_pkg for the request kinds, constants and register address.
module xs64s_checker
  import xs64s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  input  logic              req_valid,
  input  logic              req_stall,
  input  logic [1:0]        action,
  input  logic [63:0]       bound,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  logic [63:0]       value,
  output int                failures,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] gen_state;
  logic [63:0] due_values[$];
  logic [63:0] wanted;
  int          mismatch_count = 0;
  int          due_count = 0;

  assign failures = mismatch_count;
  assign pending  = due_count;

  // One state advance: three shift-xor steps, then the low half of the product.
  function automatic logic [63:0] advance_product();
    logic [63:0] x;
    x = gen_state;
    x = x ^ (x >> SHIFT_A);
    x = x ^ (x << SHIFT_B);
    x = x ^ (x >> SHIFT_C);
    gen_state = x;
    return x * STAR_MULT;
  endfunction

  // Value returned for one request. A zero bound and the unused code leave the
  // state untouched and give zero.
  function automatic logic [63:0] draw_value(input action_t kind, input logic [63:0] limit);
    logic [63:0] result;
    result = '0;
    case (kind)
      ACT_RAW: result = advance_product();
      ACT_MOD: begin
        if (limit != 0)
          result = advance_product() % limit;
      end
      ACT_FRAC: result = advance_product() >> FRAC_SHIFT;
      default: result = '0;
    endcase
    return result;
  endfunction

  // Results are retired before new requests are predicted, so an item that is
  // accepted at the same edge can never be matched against its own result.
  always @(posedge clk) begin
    if (rst) begin
      gen_state = GOLDEN_SEED;
      due_values.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
        gen_state = (pwdata != 0) ? pwdata : GOLDEN_SEED;
      if (rsp_valid && !rsp_stall) begin
        if (due_values.size() == 0) begin
          $error("value: expected nothing, actual %h", value);
          mismatch_count++;
        end else begin
          wanted = due_values.pop_front();
          if (value !== wanted) begin
            $error("value: expected %h, actual %h", wanted, value);
            mismatch_count++;
          end
        end
      end
      if (req_valid && !req_stall)
        due_values.push_back(draw_value(action_t'(action), bound));
    end
    due_count = due_values.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the xorshift64* generator testbench: clock, reset, seed writes,
// request and stall traffic, watchdog and verdict.
// Depends on xs64s_pkg, xorshift64_star_generator and xs64s_checker.
module testbench
  import xs64s_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 600;
  localparam int PHASE_ITEMS = 370;
  localparam logic [63:0] ALL_ONES = ~64'd0;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;
  logic              req_valid;
  logic              req_stall;
  action_t           action;
  logic [63:0]       bound;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [63:0]       value;
  int                failures;
  int                pending;
  logic              long_hold_go = 1'b0;
  logic              long_hold_done = 1'b0;

  xorshift64_star_generator dut (.*);

  xs64s_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic send_item(input action_t kind, input logic [63:0] limit);
    req_valid <= 1'b1;
    action    <= kind;
    bound     <= limit;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted value has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Seed write: setup cycle, then access cycle.
  task automatic write_seed(input logic [63:0] seed);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= seed;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random request, weighted toward bounded draws, with bounds spread over
  // zero, tiny values, powers of two, values near the top and full-width ones.
  task automatic send_random();
    action_t     kind;
    logic [63:0] limit;
    int          pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 30) ? ACT_RAW : (pick < 70) ? ACT_MOD : (pick < 92) ? ACT_FRAC : ACT_NONE;
    limit = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 6)
      limit = '0;
    else if (pick < 30)
      limit = 64'($urandom_range(1, 20));
    else if (pick < 45)
      limit = 64'd1 << $urandom_range(0, 63);
    else if (pick < 55)
      limit = ALL_ONES - 64'($urandom_range(0, 15));
    else if (pick < 70)
      limit = {32'd0, $urandom};
    send_item(kind, limit);
  endtask

  // Bursts of back-to-back items separated by gaps of varying length.
  task automatic run_phase(input int count);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        send_random();
        sent++;
        burst--;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25)
        idle_gap(0);
      else if (pick < 95)
        idle_gap($urandom_range(1, 10));
      else
        idle_gap($urandom_range(40, 90));
    end
  endtask

  // Receiver stall pattern, plus one long hold-off on request.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    rsp_stall = 1'b0;
    forever begin
      if (long_hold_go && !long_hold_done) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
        long_hold_done = 1'b1;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(1, 60);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
          endcase
        end
      end
    end
  end

  // End the run if nothing moves on any port for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    rst       = 1'b1;
    req_valid = 1'b0;
    action    = ACT_RAW;
    bound     = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = SEED_ADDR;
    pwdata    = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items from the reset state: bound extremes, a zero bound that
    // must not advance the state, the unused code, and bounds that are ignored.
    send_item(ACT_RAW, '0);
    send_item(ACT_RAW, ALL_ONES);
    send_item(ACT_MOD, '0);
    send_item(ACT_MOD, 64'd1);
    send_item(ACT_MOD, 64'd2);
    send_item(ACT_MOD, 64'd3);
    send_item(ACT_MOD, ALL_ONES);
    send_item(ACT_MOD, 64'h8000_0000_0000_0000);
    send_item(ACT_MOD, 64'h0000_0001_0000_0000);
    send_item(ACT_MOD, 64'h0000_0000_ffff_ffff);
    send_item(ACT_FRAC, '0);
    send_item(ACT_FRAC, ALL_ONES);
    send_item(ACT_NONE, '0);
    send_item(ACT_NONE, ALL_ONES);
    send_item(ACT_MOD, '0);
    send_item(ACT_RAW, 64'h5555_5555_5555_5555);
    send_item(ACT_MOD, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(ACT_FRAC, 64'd7);
    send_item(ACT_MOD, 64'd7);
    send_item(ACT_NONE, 64'd1);
    send_item(ACT_RAW, '0);
    wait_drained();

    // Zero seed selects the golden constant again.
    write_seed('0);
    run_phase(PHASE_ITEMS);
    wait_drained();

    // All-ones seed, with one long receiver hold-off while items keep coming.
    write_seed(ALL_ONES);
    long_hold_go = 1'b1;
    run_phase(PHASE_ITEMS);
    wait_drained();

    // Smallest nonzero seed; the sender pauses midway until all values are back.
    write_seed(64'd1);
    run_phase(PHASE_ITEMS / 2);
    wait_drained();
    run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
    wait_drained();

    write_seed(64'h8000_0000_0000_0000);
    run_phase(PHASE_ITEMS);
    wait_drained();

    write_seed({$urandom, $urandom});
    run_phase(PHASE_ITEMS);
    wait_drained();

    repeat (80) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/xs64s_pkg.sv
rtl/core/xs64s_ctrl.sv
rtl/core/xs64s_dpath.sv
rtl/core/xorshift64_star_generator.sv
verif/xs64s_checker.sv
verif/testbench.sv
